### rtl/rtc_pkg.sv
// rotate unit package: widths, operation codes, pipeline stage types and count helpers
package rtc_pkg;

    localparam int unsigned OP_W   = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned RING_W = OP_W + 1;
    localparam int unsigned RAW_CNT_W = 8;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned AMT_W  = 5;

    typedef enum logic [1:0] {
        KIND_RCL = 2'd0,
        KIND_RCR = 2'd1,
        KIND_ROL = 2'd2,
        KIND_ROR = 2'd3
    } kind_t;

    // decoded beat: ring to rotate left, its width and the left amount
    typedef struct packed {
        kind_t               kind;
        logic                word;
        logic                zero;
        logic [RING_W-1:0]   ring;
        logic [AMT_W-1:0]    ring_w;
        logic [AMT_W-1:0]    amt;
        logic [OP_W-1:0]     val;
        logic                cf;
        logic                of;
    } s1_t;

    // rotated beat
    typedef struct packed {
        kind_t               kind;
        logic                word;
        logic                zero;
        logic [RING_W-1:0]   ring;
        logic [OP_W-1:0]     val;
        logic                cf;
        logic                of;
    } s2_t;

    // count modulo 9 for counts up to 31
    function automatic logic [AMT_W-1:0] mod9(input logic [CNT_W-1:0] n);
        logic [AMT_W-1:0] r;
        begin
            if (n >= 5'd27)
            begin
                r = n - 5'd27;
            end
            else if (n >= 5'd18)
            begin
                r = n - 5'd18;
            end
            else if (n >= 5'd9)
            begin
                r = n - 5'd9;
            end
            else
            begin
                r = n;
            end
            return r;
        end
    endfunction

    // count modulo 17 for counts up to 31
    function automatic logic [AMT_W-1:0] mod17(input logic [CNT_W-1:0] n);
        logic [AMT_W-1:0] r;
        begin
            if (n >= 5'd17)
            begin
                r = n - 5'd17;
            end
            else
            begin
                r = n;
            end
            return r;
        end
    endfunction

endpackage

### rtl/rtc_in_if.sv
// rotate unit request channel
interface rtc_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic                       word_size;
    logic [rtc_pkg::OP_W-1:0]   operand_value;
    logic [rtc_pkg::RAW_CNT_W-1:0] rotate_count;
    logic                       carry_in;
    logic                       overflow_in;

    modport source (
        output valid, kind, word_size, operand_value, rotate_count, carry_in, overflow_in,
        input  ready
    );
    modport sink (
        input  valid, kind, word_size, operand_value, rotate_count, carry_in, overflow_in,
        output ready
    );
endinterface

### rtl/rtc_out_if.sv
// rotate unit result channel
interface rtc_out_if;
    logic                       valid;
    logic                       ready;
    logic [rtc_pkg::OP_W-1:0]   rotated_value;
    logic                       carry_out;
    logic                       overflow_out;

    modport source (
        output valid, rotated_value, carry_out, overflow_out,
        input  ready
    );
    modport sink (
        input  valid, rotated_value, carry_out, overflow_out,
        output ready
    );
endinterface

### rtl/rotate_through_carry_unit.sv
// rotate unit top level: three stage pipeline (decode, rotate, flags)
// a request beat is registered in the decode, rotate and flags stages in turn before its result is valid on rsp
// throughput: one beat per cycle; each stage holds while the one after it is full and stalled
// the rotate stage is a single 17-bit barrel rotate, which sets the stage depth
// reset: rst_n clears all stage valid bits asynchronously; payload registers are not reset
module rotate_through_carry_unit (
    input  logic     clk,
    input  logic     rst_n,
    rtc_in_if.sink   req,
    rtc_out_if.source rsp
);
    import rtc_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic [OP_W-1:0] res_reg, res_next;
    logic cf_reg, cf_next;
    logic of_reg, of_next;
    logic adv1, adv2, adv3;

    // per-stage advance, a stage loads when empty or when it drains
    assign adv3 = !v3_reg || rsp.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign req.ready = adv1;

    // stage 1: decode count into a left rotate of a 8, 9, 16 or 17 bit ring
    always_comb
    begin
        logic [CNT_W-1:0] n;
        logic [OP_W-1:0]  v;
        logic [AMT_W-1:0] k;
        n = req.rotate_count[CNT_W-1:0];
        v = req.word_size ? req.operand_value : {8'b0, req.operand_value[BYTE_W-1:0]};
        s1_next.kind = kind_t'(req.kind);
        s1_next.word = req.word_size;
        s1_next.zero = (n == '0);
        s1_next.val  = v;
        s1_next.cf   = req.carry_in;
        s1_next.of   = req.overflow_in;
        case (kind_t'(req.kind))
            KIND_RCL, KIND_RCR:
            begin
                s1_next.ring_w = req.word_size ? 5'd17 : 5'd9;
                s1_next.ring   = req.word_size ? {req.carry_in, v}
                                               : {8'b0, req.carry_in, v[BYTE_W-1:0]};
                k = req.word_size ? mod17(n) : mod9(n);
            end
            default:
            begin
                s1_next.ring_w = req.word_size ? 5'd16 : 5'd8;
                s1_next.ring   = {1'b0, v};
                k = req.word_size ? {1'b0, n[3:0]} : {2'b0, n[2:0]};
            end
        endcase
        // right rotate becomes a left rotate by the ring width minus the count
        if ((kind_t'(req.kind) == KIND_RCR || kind_t'(req.kind) == KIND_ROR) && k != '0)
        begin
            s1_next.amt = s1_next.ring_w - k;
        end
        else
        begin
            s1_next.amt = k;
        end
    end

    // stage 2: barrel rotate within the ring width
    always_comb
    begin
        logic [RING_W-1:0] mask;
        logic [AMT_W-1:0]  rsh;
        mask = ~({RING_W{1'b1}} << s1_reg.ring_w);
        rsh  = s1_reg.ring_w - s1_reg.amt;
        s2_next.kind = s1_reg.kind;
        s2_next.word = s1_reg.word;
        s2_next.zero = s1_reg.zero;
        s2_next.val  = s1_reg.val;
        s2_next.cf   = s1_reg.cf;
        s2_next.of   = s1_reg.of;
        s2_next.ring = ((s1_reg.ring << s1_reg.amt) | (s1_reg.ring >> rsh)) & mask;
    end

    // stage 3: extract result and flags, zero count keeps everything
    always_comb
    begin
        logic [RING_W-1:0] r;
        logic msb, nxt, c;
        r   = s2_reg.ring;
        msb = s2_reg.word ? r[OP_W-1] : r[BYTE_W-1];
        nxt = s2_reg.word ? r[OP_W-2] : r[BYTE_W-2];
        case (s2_reg.kind)
            KIND_RCL, KIND_RCR: c = s2_reg.word ? r[OP_W] : r[BYTE_W];
            KIND_ROL:           c = r[0];
            KIND_ROR:           c = msb;
            default:            c = msb;
        endcase
        if (s2_reg.zero)
        begin
            res_next = s2_reg.val;
            cf_next  = s2_reg.cf;
            of_next  = s2_reg.of;
        end
        else
        begin
            res_next = s2_reg.word ? r[OP_W-1:0] : {8'b0, r[BYTE_W-1:0]};
            cf_next  = c;
            of_next  = (s2_reg.kind == KIND_RCL || s2_reg.kind == KIND_ROL) ? (c ^ msb)
                                                                            : (msb ^ nxt);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= req.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            res_reg <= res_next;
            cf_reg  <= cf_next;
            of_reg  <= of_next;
        end
    end

    assign rsp.valid         = v3_reg;
    assign rsp.rotated_value = res_reg;
    assign rsp.carry_out     = cf_reg;
    assign rsp.overflow_out  = of_reg;

endmodule

### tb/rotate_through_carry_unit_tb.sv
// self-checking testbench for the rotate unit: directed and random beats, scoreboard class
module rotate_through_carry_unit_tb;

    import rtc_pkg::*;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned LONG_HOLD  = 80;
    localparam int unsigned RAND_BEATS = 1550;
    localparam int unsigned DRAIN_WAIT = 8;
    localparam int unsigned MAX_REPORT = 10;

    typedef struct packed {
        kind_t                  kind;
        logic                   word_size;
        logic [OP_W-1:0]        operand_value;
        logic [RAW_CNT_W-1:0]   rotate_count;
        logic                   carry_in;
        logic                   overflow_in;
    } rot_req_t;

    typedef struct packed {
        logic [OP_W-1:0]        rotated_value;
        logic                   carry_out;
        logic                   overflow_out;
    } rot_rsp_t;

    // predicts each rotate and matches results in order
    class rotate_scoreboard;
        rot_rsp_t    expected_q[$];
        int unsigned failures;
        int unsigned checked;

        function rot_rsp_t predict_rotate(rot_req_t r);
            rot_rsp_t    p;
            logic [15:0] val;
            logic        cf;
            logic        of;
            logic        out_bit;
            int unsigned w;
            int unsigned steps;
            w     = r.word_size ? 16 : 8;
            val   = r.word_size ? r.operand_value : {8'h00, r.operand_value[7:0]};
            cf    = r.carry_in;
            of    = r.overflow_in;
            steps = 32'(r.rotate_count[4:0]);
            // walk the count one bit position per pass
            for (int i = 0; i < steps; i++)
            begin
                case (r.kind)
                    KIND_RCL:
                    begin
                        out_bit = val[w-1];
                        val     = (val << 1) | cf;
                        cf      = out_bit;
                    end
                    KIND_RCR:
                    begin
                        out_bit   = val[0];
                        val       = val >> 1;
                        val[w-1]  = cf;
                        cf        = out_bit;
                    end
                    KIND_ROL:
                    begin
                        out_bit = val[w-1];
                        val     = (val << 1) | out_bit;
                        cf      = out_bit;
                    end
                    default:
                    begin
                        out_bit   = val[0];
                        val       = val >> 1;
                        val[w-1]  = out_bit;
                        cf        = out_bit;
                    end
                endcase
                if (w == 8)
                begin
                    val[15:8] = 8'h00;
                end
            end
            // overflow only moves on a nonzero count
            if (steps != 0)
            begin
                if (r.kind == KIND_RCL || r.kind == KIND_ROL)
                begin
                    of = cf ^ val[w-1];
                end
                else
                begin
                    of = val[w-1] ^ val[w-2];
                end
            end
            p.rotated_value = val;
            p.carry_out     = cf;
            p.overflow_out  = of;
            return p;
        endfunction

        function void note_request(rot_req_t r);
            expected_q.push_back(predict_rotate(r));
        endfunction

        function void check_result(rot_rsp_t got);
            rot_rsp_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORT)
                begin
                    $display("result beat %0d with nothing pending: value=%h cf=%b of=%b",
                             checked, got.rotated_value, got.carry_out, got.overflow_out);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.rotated_value !== want.rotated_value ||
                    got.carry_out !== want.carry_out ||
                    got.overflow_out !== want.overflow_out)
                begin
                    failures++;
                    if (failures <= MAX_REPORT)
                    begin
                        $display({"result beat %0d mismatch: expected value=%h cf=%b of=%b, ",
                                  "got value=%h cf=%b of=%b"},
                                 checked, want.rotated_value, want.carry_out, want.overflow_out,
                                 got.rotated_value, got.carry_out, got.overflow_out);
                    end
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   long_hold_req;

    rtc_in_if  req_ch ();
    rtc_out_if rsp_ch ();

    rotate_scoreboard sb;

    wire req_fire = req_ch.valid && req_ch.ready;
    wire rsp_fire = rsp_ch.valid && rsp_ch.ready;

    rotate_through_carry_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // offer one request beat and hold it until taken
    task automatic send_beat(input rot_req_t r);
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= r.kind;
        req_ch.word_size     <= r.word_size;
        req_ch.operand_value <= r.operand_value;
        req_ch.rotate_count  <= r.rotate_count;
        req_ch.carry_in      <= r.carry_in;
        req_ch.overflow_in   <= r.overflow_in;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_sender(input int unsigned cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending until every pending result is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // beat monitor on both channels
    always @(posedge clk)
    begin
        rot_req_t seen;
        rot_rsp_t got;
        if (rst_n && req_fire)
        begin
            seen.kind          = kind_t'(req_ch.kind);
            seen.word_size     = req_ch.word_size;
            seen.operand_value = req_ch.operand_value;
            seen.rotate_count  = req_ch.rotate_count;
            seen.carry_in      = req_ch.carry_in;
            seen.overflow_in   = req_ch.overflow_in;
            sb.note_request(seen);
        end
        if (rst_n && rsp_fire)
        begin
            got.rotated_value = rsp_ch.rotated_value;
            got.carry_out     = rsp_ch.carry_out;
            got.overflow_out  = rsp_ch.overflow_out;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no beat on either side
    int unsigned idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || req_fire || rsp_fire)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: segments of varying stall rate, plus one long hold-off on request
    initial
    begin
        int unsigned seg_left;
        int unsigned rx_pct;
        seg_left = 0;
        rx_pct   = 0;
        do
        begin
            @(posedge clk);
        end
        while (!rst_n);
        forever
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(50, 300);
                case ($urandom_range(0, 2))
                    0: rx_pct = 0;
                    1: rx_pct = 25;
                    default: rx_pct = 60;
                endcase
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            seg_left--;
        end
    end

    // reset and stimulus
    initial
    begin
        rot_req_t    r;
        int unsigned tx_pct;
        int unsigned ring_len;
        sb = new();
        long_hold_req        = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_RCL;
        req_ch.word_size     = 1'b0;
        req_ch.operand_value = '0;
        req_ch.rotate_count  = '0;
        req_ch.carry_in      = 1'b0;
        req_ch.overflow_in   = 1'b0;
        rsp_ch.ready         = 1'b0;
        tx_pct               = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero count, count equal to the ring length, full raw count
        for (int k = 0; k < 4; k++)
        begin
            for (int ws = 0; ws < 2; ws++)
            begin
                r.kind      = kind_t'(k);
                r.word_size = ws[0];
                if (r.kind == KIND_RCL || r.kind == KIND_RCR)
                begin
                    ring_len = ws ? 17 : 9;
                end
                else
                begin
                    ring_len = ws ? 16 : 8;
                end
                // zero count keeps both flags, byte with upper bits set
                r.operand_value = 16'hFFFF;
                r.rotate_count  = 8'h00;
                r.carry_in      = 1'b1;
                r.overflow_in   = ws[0];
                send_beat(r);
                // full ring turn returns the value
                r.operand_value = 16'hA5C3;
                r.rotate_count  = ring_len[7:0];
                r.carry_in      = ws[0];
                r.overflow_in   = 1'b1;
                send_beat(r);
                // all count bits set, only the low five count
                r.operand_value = ws ? 16'h0001 : 16'h0000;
                r.rotate_count  = 8'hFF;
                r.carry_in      = 1'b1;
                r.overflow_in   = 1'b0;
                send_beat(r);
            end
        end
        wait_drained();

        // random beats
        for (int n = 0; n < RAND_BEATS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: tx_pct = 0;
                    1: tx_pct = 20;
                    default: tx_pct = 50;
                endcase
            end
            // long receiver hold-off while the sender keeps offering
            if (n == 500)
            begin
                long_hold_req = 1'b1;
                tx_pct        = 0;
            end
            // sender pause until the pipe is empty
            if (n == 1000)
            begin
                wait_drained();
            end
            r.kind      = kind_t'($urandom_range(0, 3));
            r.word_size = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: r.operand_value = 16'h0000;
                    1: r.operand_value = 16'hFFFF;
                    2: r.operand_value = 16'h8000;
                    3: r.operand_value = 16'h0080;
                    default: r.operand_value = 16'h4040;
                endcase
            end
            else
            begin
                r.operand_value = 16'($urandom);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: r.rotate_count = {3'($urandom_range(0, 7)), 5'd0};
                    1: r.rotate_count = 8'd8;
                    2: r.rotate_count = 8'd9;
                    3: r.rotate_count = 8'd16;
                    default: r.rotate_count = 8'd17;
                endcase
            end
            else
            begin
                r.rotate_count = 8'($urandom_range(0, 255));
            end
            r.carry_in    = 1'($urandom_range(0, 1));
            r.overflow_in = 1'($urandom_range(0, 1));
            send_beat(r);
            if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct)
            begin
                idle_sender(gap_len());
            end
        end

        // drain and settle
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        sb.failures += sb.expected_q.size();
        if (sb.failures == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rtc_pkg.sv
rtl/rtc_in_if.sv
rtl/rtc_out_if.sv
rtl/rotate_through_carry_unit.sv
tb/rotate_through_carry_unit_tb.sv
